// ----- sv/hnwm_pkg.sv -----
`default_nettype none
package hnwm_pkg;

  localparam int CMD_W       = 2;
  localparam int LETTER_W    = 5;
  localparam int MAX_LETTERS = 8;
  localparam int CHARS_W     = LETTER_W * MAX_LETTERS;
  localparam int LEN_W       = 4;
  localparam int DIST_W      = 4;
  localparam int STATUS_W    = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_CORRECT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SUGGEST = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  // one dictionary entry as it sits in a cell
  typedef struct packed {
    logic [CHARS_W-1:0] letters;
    logic [LEN_W-1:0]   len;
    logic               tie;
  } cell_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic clr_tie;
  } cell_ctrl_t;

  // zero the letter slots at and above len
  function automatic logic [CHARS_W-1:0] mask_letters(input logic [CHARS_W-1:0] chars,
                                                       input logic [LEN_W-1:0]   len);
    logic [CHARS_W-1:0] res;
    res = '0;
    for (int i = 0; i < MAX_LETTERS; i++) begin
      if (LEN_W'(i) < len) begin
        res[i*LETTER_W +: LETTER_W] = chars[i*LETTER_W +: LETTER_W];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/hamming_nearest_word_match_unit.sv -----
`default_nettype none
// Nearest-word matcher: a dictionary of up to MAX_WORDS words of up to eight 5-bit letters
// lives in a ring of cells that rotates past one Hamming comparator at the head. Clear and
// store each give one word. A query rotates the ring once past the comparator, then decides,
// and for correct or no-close-match gives one word; when it has suggestions the ring turns
// once more and gives one word per tied entry in store order, holding on any output stall.
module hamming_nearest_word_match_unit
  import hnwm_pkg::*;
#(
  parameter int MAX_WORDS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [CMD_W-1:0]     cmd_i,
  input  wire  [CHARS_W-1:0]   word_chars_i,
  input  wire  [LEN_W-1:0]     word_len_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [DIST_W-1:0]    distance_o,
  output logic [CHARS_W-1:0]   match_chars_o,
  output logic                 last_o
);

  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   ties_q, ties_d;
  logic [DIST_W-1:0]  best_q, best_d;
  logic [CHARS_W-1:0] q_chars_q, q_chars_d;
  logic [LEN_W-1:0]   q_len_q, q_len_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [DIST_W-1:0]   dist_q;
  logic [CHARS_W-1:0]  match_q;
  logic                last_q;

  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [DIST_W-1:0]   emit_dist;
  logic [CHARS_W-1:0]  emit_chars;
  logic                emit_last;

  logic               out_ready, accept, last_step, in_range, better, equal;
  logic               shift_en, clr_tie, load_en, tie_in;
  logic [LEN_W-1:0]   len_c;
  logic [DIST_W-1:0]  head_dist;
  cell_t              cells [MAX_WORDS];
  cell_t              head, tail, load_data;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == S_IDLE && out_ready);
  assign accept     = in_valid_i && !in_stall_o;

  assign len_c = (word_len_i > LEN_W'(MAX_LETTERS)) ? LEN_W'(MAX_LETTERS) : word_len_i;

  assign head      = cells[0];
  assign last_step = (step_q == IDX_W'(MAX_WORDS - 1));
  assign in_range  = (CNT_W'(step_q) < count_q);

  hnwm_score u_score (
    .entry_i   (head),
    .q_chars_i (q_chars_q),
    .q_len_i   (q_len_q),
    .dist_o    (head_dist)
  );

  assign better = in_range && (head_dist < best_q);
  assign equal  = in_range && (head_dist == best_q);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    ties_d      = ties_q;
    best_d      = best_q;
    q_chars_d   = q_chars_q;
    q_len_d     = q_len_q;
    shift_en    = 1'b0;
    clr_tie     = 1'b0;
    load_en     = 1'b0;
    tie_in      = head.tie;
    emit        = 1'b0;
    emit_status = ST_CORRECT;
    emit_dist   = '0;
    emit_chars  = '0;
    emit_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_CLEAR: begin
              count_d     = '0;
              emit        = 1'b1;
              emit_status = ST_CLEARED;
            end
            CMD_STORE: begin
              emit = 1'b1;
              if (count_q >= CNT_W'(MAX_WORDS)) begin
                emit_status = ST_FULL;
              end else begin
                load_en     = 1'b1;
                count_d     = count_q + CNT_W'(1);
                emit_status = ST_STORED;
              end
            end
            CMD_QUERY: begin
              q_chars_d = word_chars_i;
              q_len_d   = len_c;
              best_d    = DIST_W'(len_c);
              ties_d    = '0;
              step_d    = '0;
              state_d   = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        shift_en = 1'b1;
        tie_in   = better || equal;
        if (better) begin
          best_d  = head_dist;
          clr_tie = 1'b1;
          ties_d  = CNT_W'(1);
        end else if (equal) begin
          ties_d = ties_q + CNT_W'(1);
        end
        if (last_step) begin
          step_d  = '0;
          state_d = S_DECIDE;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end
      S_DECIDE: begin
        if (out_ready) begin
          if (best_q > DIST_W'(q_len_q >> 1)) begin
            emit        = 1'b1;
            emit_status = ST_NOMATCH;
            state_d     = S_IDLE;
          end else if (best_q == '0) begin
            emit        = 1'b1;
            emit_status = ST_CORRECT;
            state_d     = S_IDLE;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!head.tie || out_ready) begin
          shift_en = 1'b1;
          if (head.tie) begin
            emit        = 1'b1;
            emit_status = ST_SUGGEST;
            emit_dist   = best_q;
            emit_chars  = head.letters;
            emit_last   = (ties_q == CNT_W'(1));
            ties_d      = ties_q - CNT_W'(1);
          end
          if (last_step) begin
            step_d  = '0;
            state_d = S_IDLE;
          end else begin
            step_d = step_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // the head re-enters at the tail, with its fresh tie bit during a scan
  always_comb begin
    tail     = head;
    tail.tie = tie_in;
    load_data.letters = mask_letters(word_chars_i, len_c);
    load_data.len     = len_c;
    load_data.tie     = 1'b0;
  end

  for (genvar k = 0; k < MAX_WORDS; k++) begin : g_cell
    cell_ctrl_t ctrl;
    cell_t      nbr;
    assign ctrl.shift = shift_en;
    assign ctrl.load  = load_en && (count_q == CNT_W'(k));
    if (k == MAX_WORDS - 1) begin : g_tail
      assign ctrl.clr_tie = 1'b0;
      assign nbr          = tail;
    end else begin : g_mid
      assign ctrl.clr_tie = clr_tie;
      assign nbr          = cells[k+1];
    end
    hnwm_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .nbr_i       (nbr),
      .load_data_i (load_data),
      .cell_o      (cells[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      ties_q      <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      ties_q  <= ties_d;
      best_q  <= best_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_chars_q <= q_chars_d;
    q_len_q   <= q_len_d;
    if (emit) begin
      status_q <= emit_status;
      dist_q   <= emit_dist;
      match_q  <= emit_chars;
      last_q   <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign distance_o    = dist_q;
  assign match_chars_o = match_q;
  assign last_o        = last_q;

  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == S_IDLE)
    else $error("word accepted while a query is in progress");

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_WORDS))
    else $error("word count beyond dictionary depth");

  a_tie_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && head.tie) |-> ties_q != '0)
    else $error("tied entry found with no suggestions left");

  a_suggest_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_SUGGEST) |-> distance_o != '0)
    else $error("suggestion with zero distance");

endmodule
`default_nettype wire

// ----- sv/hnwm_cell.sv -----
`default_nettype none
module hnwm_cell
  import hnwm_pkg::*;
(
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  cell_t      nbr_i,
  input  cell_t      load_data_i,
  output cell_t      cell_o
);

  cell_t cell_q, cell_d;

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.load) begin
      cell_d = load_data_i;
    end else if (ctrl_i.shift) begin
      cell_d     = nbr_i;
      cell_d.tie = nbr_i.tie & ~ctrl_i.clr_tie;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// ----- sv/hnwm_score.sv -----
`default_nettype none
module hnwm_score
  import hnwm_pkg::*;
(
  input  cell_t              entry_i,
  input  logic [CHARS_W-1:0] q_chars_i,
  input  logic [LEN_W-1:0]   q_len_i,
  output logic [DIST_W-1:0]  dist_o
);

  logic [DIST_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < MAX_LETTERS; i++) begin
      if (LEN_W'(i) < q_len_i &&
          entry_i.letters[i*LETTER_W +: LETTER_W] != q_chars_i[i*LETTER_W +: LETTER_W]) begin
        cnt = cnt + DIST_W'(1);
      end
    end
    // a word of another length scores the query length
    if (entry_i.len != q_len_i) begin
      dist_o = DIST_W'(q_len_i);
    end else begin
      dist_o = cnt;
    end
  end

endmodule
`default_nettype wire
